### hw/rtl/obbsat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared types and constants for the oriented box pair overlap test.
// ----------------------------------------------------------------------------
package obbsat_pkg;

  // default coordinate width of centers and half extents
  localparam int unsigned CoordWidthDef = 16;

  // axis components are signed Q1.14 in 16-bit slots
  localparam int unsigned AxisW    = 16;
  localparam int unsigned AxisFrac = 14;

  // rotation dot product, rounded rotation and biased absolute rotation
  localparam int unsigned QW  = 2 * AxisW + 2;
  localparam int unsigned RW  = QW - AxisFrac + 1;
  localparam int unsigned FRW = RW + 2;

  // bias register
  localparam int unsigned BiasW     = 8;
  localparam logic [BiasW-1:0] BiasReset = 8'd1;

  // axis codes
  localparam int unsigned NumAxes = 15;
  localparam logic [3:0]  SepNone = 4'd15;

  // input item
  typedef struct packed {
    logic [15:0] pair_tag;
    logic [47:0] a_center;
    logic [47:0] a_axis_x;
    logic [47:0] a_axis_y;
    logic [47:0] a_axis_z;
    logic [47:0] a_half_size;
    logic [47:0] b_center;
    logic [47:0] b_axis_x;
    logic [47:0] b_axis_y;
    logic [47:0] b_axis_z;
    logic [47:0] b_half_size;
  } obb_in_t;

  // result item
  typedef struct packed {
    logic [15:0] tag_out;
    logic        overlap;
    logic [3:0]  first_separating_axis;
  } obb_out_t;

endpackage

### hw/rtl/obb_obb_separating_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test
// Oriented box pair overlap test over the 15 separating axes, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | signals                               | payload
//  --------+-----+---------------------------------------+----------------------
//  in      | in  | in_valid_i / in_ready_o / in_data_i   | obb_in_t box pair
//  out     | out | out_valid_o / out_ready_i / out_data_o| obb_out_t hit, axis
//  cfg     | in  | cfg_valid_i / cfg_ready_o / cfg_data_i| abs_bias, 8 bits
//
//  one box pair per cycle while the output is not stalled; five register stages
//  (products, sums and rounding, products, compares, encode)
//  reset clears the stage valid bits and loads abs_bias with 1
//  a stalled output only holds the stages that are full; bubbles close up
//  cfg_ready_o is always high
// ----------------------------------------------------------------------------
module obb_obb_separating_axis_test #(
  parameter int unsigned COORD_WIDTH = obbsat_pkg::CoordWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  obbsat_pkg::obb_in_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output obbsat_pkg::obb_out_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [obbsat_pkg::BiasW-1:0]      cfg_data_i
);
  import obbsat_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned VW   = CW + 1;
  localparam int unsigned VPW  = VW + AxisW;
  localparam int unsigned TW   = VPW + 2;
  localparam int unsigned PW   = 2 * AxisW;
  localparam int unsigned HPW  = CW + FRW;
  localparam int unsigned TRW  = TW + RW;
  localparam int unsigned CMPW = TRW + 3;

  // bias register
  logic [BiasW-1:0] bias_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= BiasReset;
    end else if (cfg_valid_i) begin
      bias_q <= cfg_data_i;
    end
  end

  // stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic ld1, ld2, ld3, ld4, ld5;

  always_comb begin
    ld5 = !vo_q || out_ready_i;
    ld4 = !v4_q || ld5;
    ld3 = !v3_q || ld4;
    ld2 = !v2_q || ld3;
    ld1 = !v1_q || ld2;
  end

  assign in_ready_o  = ld1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) vo_q <= v4_q;
    end
  end

  // stage 1: unpack, center offset, axis products
  logic [63:0] ca_w, cb_w, ha_w, hb_w;
  logic [63:0] ax_w [3];
  logic [63:0] bx_w [3];
  logic signed [CW-1:0]    ca [3];
  logic signed [CW-1:0]    cb [3];
  logic signed [CW-1:0]    ha [3];
  logic signed [CW-1:0]    hb [3];
  logic signed [AxisW-1:0] ax [3][3];
  logic signed [AxisW-1:0] bx [3][3];
  logic signed [VW-1:0]    v  [3];

  always_comb begin
    ca_w = {16'b0, in_data_i.a_center};
    cb_w = {16'b0, in_data_i.b_center};
    ha_w = {16'b0, in_data_i.a_half_size};
    hb_w = {16'b0, in_data_i.b_half_size};
    ax_w[0] = {16'b0, in_data_i.a_axis_x};
    ax_w[1] = {16'b0, in_data_i.a_axis_y};
    ax_w[2] = {16'b0, in_data_i.a_axis_z};
    bx_w[0] = {16'b0, in_data_i.b_axis_x};
    bx_w[1] = {16'b0, in_data_i.b_axis_y};
    bx_w[2] = {16'b0, in_data_i.b_axis_z};
    for (int k = 0; k < 3; k++) begin
      ca[k] = ca_w[k*CW +: CW];
      cb[k] = cb_w[k*CW +: CW];
      ha[k] = ha_w[k*CW +: CW];
      hb[k] = hb_w[k*CW +: CW];
      v[k]  = VW'(cb[k]) - VW'(ca[k]);
      for (int i = 0; i < 3; i++) begin
        ax[i][k] = ax_w[i][k*AxisW +: AxisW];
        bx[i][k] = bx_w[i][k*AxisW +: AxisW];
      end
    end
  end

  logic signed [PW-1:0]  axp_q [3][3][3];
  logic signed [VPW-1:0] vap_q [3][3];
  logic signed [CW-1:0]  ha1_q [3];
  logic signed [CW-1:0]  hb1_q [3];
  logic [15:0]           tag1_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      tag1_q <= in_data_i.pair_tag;
      for (int i = 0; i < 3; i++) begin
        ha1_q[i] <= ha[i];
        hb1_q[i] <= hb[i];
        for (int k = 0; k < 3; k++) begin
          vap_q[i][k] <= VPW'(v[k]) * VPW'(ax[i][k]);
          for (int j = 0; j < 3; j++) begin
            axp_q[i][j][k] <= PW'(ax[i][k]) * PW'(bx[j][k]);
          end
        end
      end
    end
  end

  // stage 2: projected offset, rounded rotation, biased absolute rotation
  logic signed [TW-1:0]  t_d  [3];
  logic signed [QW-1:0]  q_d  [3][3];
  logic signed [QW-1:0]  qs_d [3][3];
  logic signed [RW-1:0]  r_d  [3][3];
  logic [RW-1:0]         ra_d [3][3];
  logic signed [FRW-1:0] fr_d [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = TW'(vap_q[i][0]) + TW'(vap_q[i][1]) + TW'(vap_q[i][2]);
      for (int j = 0; j < 3; j++) begin
        q_d[i][j]  = QW'(axp_q[i][j][0]) + QW'(axp_q[i][j][1]) + QW'(axp_q[i][j][2]);
        // round half up, then floor shift
        qs_d[i][j] = (q_d[i][j] + QW'(1 << (AxisFrac - 1))) >>> AxisFrac;
        r_d[i][j]  = qs_d[i][j][RW-1:0];
        ra_d[i][j] = r_d[i][j][RW-1] ? RW'(-r_d[i][j]) : RW'(r_d[i][j]);
        fr_d[i][j] = FRW'(ra_d[i][j]) + FRW'(bias_q);
      end
    end
  end

  logic signed [TW-1:0]  t2_q  [3];
  logic signed [RW-1:0]  r2_q  [3][3];
  logic signed [FRW-1:0] fr2_q [3][3];
  logic signed [CW-1:0]  ha2_q [3];
  logic signed [CW-1:0]  hb2_q [3];
  logic [15:0]           tag2_q;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      tag2_q <= tag1_q;
      for (int i = 0; i < 3; i++) begin
        t2_q[i]  <= t_d[i];
        ha2_q[i] <= ha1_q[i];
        hb2_q[i] <= hb1_q[i];
        for (int j = 0; j < 3; j++) begin
          r2_q[i][j]  <= r_d[i][j];
          fr2_q[i][j] <= fr_d[i][j];
        end
      end
    end
  end

  // stage 3: radius and distance products
  // tr[a][b][j] = t[a]*r[b][j], hafr[x][y][j] = ha[x]*fr[y][j],
  // hbfr[y][i][x] = hb[y]*fr[i][x]
  logic signed [TRW-1:0] tr3_q   [3][3][3];
  logic signed [HPW-1:0] hafr3_q [3][3][3];
  logic signed [HPW-1:0] hbfr3_q [3][3][3];
  logic signed [TW-1:0]  t3_q  [3];
  logic signed [CW-1:0]  ha3_q [3];
  logic signed [CW-1:0]  hb3_q [3];
  logic [15:0]           tag3_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      tag3_q <= tag2_q;
      for (int a = 0; a < 3; a++) begin
        t3_q[a]  <= t2_q[a];
        ha3_q[a] <= ha2_q[a];
        hb3_q[a] <= hb2_q[a];
        for (int b = 0; b < 3; b++) begin
          for (int j = 0; j < 3; j++) begin
            tr3_q[a][b][j]   <= TRW'(t2_q[a]) * TRW'(r2_q[b][j]);
            hafr3_q[a][b][j] <= HPW'(ha2_q[a]) * HPW'(fr2_q[b][j]);
            hbfr3_q[a][b][j] <= HPW'(hb2_q[a]) * HPW'(fr2_q[b][j]);
          end
        end
      end
    end
  end

  // stage 4: the 15 axis compares
  logic signed [CMPW-1:0] d_w  [NumAxes];
  logic signed [CMPW-1:0] ra_w [NumAxes];
  logic signed [CMPW-1:0] rb_w [NumAxes];
  logic [NumAxes-1:0]     sep_w;

  for (genvar i = 0; i < 3; i++) begin : g_face
    // face axes of box A
    assign d_w[i]  = CMPW'(t3_q[i]);
    assign ra_w[i] = CMPW'(ha3_q[i]) <<< AxisFrac;
    assign rb_w[i] = CMPW'(hbfr3_q[0][i][0]) + CMPW'(hbfr3_q[1][i][1])
                   + CMPW'(hbfr3_q[2][i][2]);
    // face axes of box B
    assign d_w[3+i]  = CMPW'(tr3_q[0][0][i]) + CMPW'(tr3_q[1][1][i])
                     + CMPW'(tr3_q[2][2][i]);
    assign ra_w[3+i] = (CMPW'(hafr3_q[0][0][i]) + CMPW'(hafr3_q[1][1][i])
                     + CMPW'(hafr3_q[2][2][i])) <<< AxisFrac;
    assign rb_w[3+i] = CMPW'(hb3_q[i]) <<< (2 * AxisFrac);
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross_i
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    for (genvar j = 0; j < 3; j++) begin : g_cross_j
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      localparam int N  = 6 + i * 3 + j;
      assign d_w[N]  = CMPW'(tr3_q[I2][I1][j]) - CMPW'(tr3_q[I1][I2][j]);
      assign ra_w[N] = (CMPW'(hafr3_q[I1][I2][j]) + CMPW'(hafr3_q[I2][I1][j]))
                       <<< AxisFrac;
      assign rb_w[N] = (CMPW'(hbfr3_q[J1][i][J2]) + CMPW'(hbfr3_q[J2][i][J1]))
                       <<< AxisFrac;
    end
  end

  for (genvar n = 0; n < NumAxes; n++) begin : g_test
    obbsat_axis_test #(
      .W (CMPW)
    ) u_test (
      .d_i   (d_w[n]),
      .ra_i  (ra_w[n]),
      .rb_i  (rb_w[n]),
      .sep_o (sep_w[n])
    );
  end

  logic [NumAxes-1:0] sep4_q;
  logic [15:0]        tag4_q;

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      sep4_q <= sep_w;
      tag4_q <= tag3_q;
    end
  end

  // stage 5: first separating axis
  logic [3:0] first_d;

  always_comb begin
    first_d = SepNone;
    for (int n = NumAxes - 1; n >= 0; n--) begin
      if (sep4_q[n]) first_d = 4'(n);
    end
  end

  obb_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      out_q.tag_out               <= tag4_q;
      out_q.overlap               <= (first_d == SepNone);
      out_q.first_separating_axis <= first_d;
    end
  end

  assign out_data_o = out_q;

  // checks
  a_overlap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overlap == (out_data_o.first_separating_axis == SepNone)))
    else $error("overlap flag disagrees with axis code");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && out_valid_o && !out_ready_i))
    else $error("input stalled with a free stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !v4_q && !out_valid_o) |-> in_ready_o)
    else $error("empty pipeline not ready");

endmodule

### hw/rtl/obbsat_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_axis_test
// One separating-axis compare: |d| strictly greater than ra + rb.
// ----------------------------------------------------------------------------
module obbsat_axis_test #(
  parameter int unsigned W = 59
) (
  input  logic signed [W-1:0] d_i,
  input  logic signed [W-1:0] ra_i,
  input  logic signed [W-1:0] rb_i,
  output logic                sep_o
);

  logic signed [W:0] abs_d;
  logic signed [W:0] rad;

  // one guard bit keeps the negate and the sum exact
  always_comb begin
    abs_d = d_i[W-1] ? -(W+1)'(d_i) : (W+1)'(d_i);
    rad   = (W+1)'(ra_i) + (W+1)'(rb_i);
    sep_o = abs_d > rad;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams oriented box pairs through the overlap test and checks each hit
// flag and first separating axis against an in-bench integer model.
// ----------------------------------------------------------------------------
module tb;
  import obbsat_pkg::*;

  localparam int unsigned CW = CoordWidthDef;

  // scoreboard: predicts the result of each accepted pair and checks outputs
  class obb_scoreboard;
    obb_out_t   pending_q[$];
    logic [7:0] bias;
    int         n_err;
    int         n_checked;
    int         n_hits;

    function new();
      bias = BiasReset;
      n_err = 0;
      n_checked = 0;
      n_hits = 0;
    endfunction

    function automatic longint get_slot(logic [47:0] w, int idx, int width);
      logic [63:0] v;
      v = {16'd0, w} >> (idx * width);
      v = v & ((64'd1 << width) - 1);
      if (v[width-1]) return longint'(v) - (longint'(1) << width);
      return longint'(v);
    endfunction

    function automatic longint mag(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // round half up from q28 to q14
    function automatic longint round_q14(longint x);
      return (x + 8192) >>> 14;
    endfunction

    function automatic obb_out_t predict(obb_in_t p);
      longint ca[3], cb[3], ha[3], hb[3], ax[3][3], bx[3][3];
      longint t[3], r[3][3], fr[3][3];
      longint ra, rb, d, q;
      logic [47:0] aw[3], bw[3];
      logic [3:0] sep;
      obb_out_t res;
      aw[0] = p.a_axis_x; aw[1] = p.a_axis_y; aw[2] = p.a_axis_z;
      bw[0] = p.b_axis_x; bw[1] = p.b_axis_y; bw[2] = p.b_axis_z;
      for (int k = 0; k < 3; k++) begin
        ca[k] = get_slot(p.a_center, k, CW);
        cb[k] = get_slot(p.b_center, k, CW);
        ha[k] = get_slot(p.a_half_size, k, CW);
        hb[k] = get_slot(p.b_half_size, k, CW);
        for (int m = 0; m < 3; m++) begin
          ax[k][m] = get_slot(aw[k], m, AxisW);
          bx[k][m] = get_slot(bw[k], m, AxisW);
        end
      end
      for (int i = 0; i < 3; i++) begin
        t[i] = 0;
        for (int k = 0; k < 3; k++) t[i] += (cb[k] - ca[k]) * ax[i][k];
        for (int j = 0; j < 3; j++) begin
          q = ax[i][0] * bx[j][0] + ax[i][1] * bx[j][1] + ax[i][2] * bx[j][2];
          r[i][j] = round_q14(q);
          fr[i][j] = mag(r[i][j]) + longint'(bias);
        end
      end
      sep = SepNone;
      // box A face normals
      for (int i = 0; i < 3; i++) begin
        if (sep == SepNone) begin
          ra = ha[i] * 16384;
          rb = hb[0] * fr[i][0] + hb[1] * fr[i][1] + hb[2] * fr[i][2];
          if (mag(t[i]) > ra + rb) sep = 4'(i);
        end
      end
      // box B face normals
      for (int i = 0; i < 3; i++) begin
        if (sep == SepNone) begin
          ra = (ha[0] * fr[0][i] + ha[1] * fr[1][i] + ha[2] * fr[2][i]) * 16384;
          rb = hb[i] * (longint'(1) << 28);
          d = t[0] * r[0][i] + t[1] * r[1][i] + t[2] * r[2][i];
          if (mag(d) > ra + rb) sep = 4'(3 + i);
        end
      end
      // edge cross products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (sep == SepNone) begin
            ra = (ha[(i+1)%3] * fr[(i+2)%3][j] + ha[(i+2)%3] * fr[(i+1)%3][j]) * 16384;
            rb = (hb[(j+1)%3] * fr[i][(j+2)%3] + hb[(j+2)%3] * fr[i][(j+1)%3]) * 16384;
            d = t[(i+2)%3] * r[(i+1)%3][j] - t[(i+1)%3] * r[(i+2)%3][j];
            if (mag(d) > ra + rb) sep = 4'(6 + i * 3 + j);
          end
        end
      end
      res.tag_out = p.pair_tag;
      res.overlap = (sep == SepNone);
      res.first_separating_axis = sep;
      return res;
    endfunction

    function void note_pair(obb_in_t p);
      pending_q.push_back(predict(p));
    endfunction

    function void check_result(obb_out_t got);
      obb_out_t want;
      n_checked++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.overlap) n_hits++;
      if (got !== want) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR: tag exp %h got %h, overlap exp %b got %b, axis exp %0d got %0d",
                   want.tag_out, got.tag_out, want.overlap, got.overlap,
                   want.first_separating_axis, got.first_separating_axis);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  obb_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  obb_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_sent = 0;

  obb_scoreboard sb = new();

  obb_obb_separating_axis_test dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // output side: random stalls and result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid drops only for idle cycles, so back-to-back transfers keep it high
  task automatic send_pair(obb_in_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (($urandom_range(99) < send_idle_pct)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pair(p);
    n_sent++;
  endtask

  task automatic write_bias(logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.bias = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [47:0] pack3(int x, int y, int z, int width);
    logic [63:0] m;
    m = (64'd1 << width) - 1;
    return 48'((64'(x) & m) | ((64'(y) & m) << width) | ((64'(z) & m) << (2 * width)));
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // random pair: mostly sensible rotations near each other, some raw noise
  function automatic obb_in_t rand_pair();
    obb_in_t p;
    int kind, sp;
    logic [47:0] ax[6];
    kind = $urandom_range(9);
    p.pair_tag = 16'($urandom);
    if (kind == 0) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 16'($urandom)};
      return p;
    end
    sp = (kind < 5) ? 400 : 4000;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(3))
        0: ax[i] = pack3(16384 * ((i % 3) == 0), 16384 * ((i % 3) == 1),
                         16384 * ((i % 3) == 2), AxisW);
        1: ax[i] = pack3(rnd_coord(16384), rnd_coord(16384), rnd_coord(16384), AxisW);
        2: ax[i] = pack3(rnd_coord(11585), rnd_coord(11585), 0, AxisW);
        default: ax[i] = {$urandom, 16'($urandom)};
      endcase
    end
    p.a_axis_x = ax[0]; p.a_axis_y = ax[1]; p.a_axis_z = ax[2];
    p.b_axis_x = ax[3]; p.b_axis_y = ax[4]; p.b_axis_z = ax[5];
    p.a_center = pack3(rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), CW);
    p.b_center = pack3(rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), CW);
    p.a_half_size = pack3($urandom_range(sp), $urandom_range(sp), $urandom_range(sp), CW);
    p.b_half_size = pack3($urandom_range(sp), $urandom_range(sp), rnd_coord(sp), CW);
    return p;
  endfunction

  initial begin
    obb_in_t p;
    logic [47:0] ident[3];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: aligned boxes, extremes, degenerate and negative cases
    ident[0] = pack3(16384, 0, 0, AxisW);
    ident[1] = pack3(0, 16384, 0, AxisW);
    ident[2] = pack3(0, 0, 16384, AxisW);
    for (int n = 0; n < 20; n++) begin
      p = '0;
      p.pair_tag = 16'(n);
      p.a_axis_x = ident[0]; p.a_axis_y = ident[1]; p.a_axis_z = ident[2];
      p.b_axis_x = ident[0]; p.b_axis_y = ident[1]; p.b_axis_z = ident[2];
      p.a_half_size = pack3(100, 100, 100, CW);
      p.b_half_size = pack3(100, 100, 100, CW);
      case (n)
        1: p.b_center = pack3(300, 0, 0, CW);
        2: p.b_center = pack3(0, 300, 0, CW);
        3: p.b_center = pack3(0, 0, -300, CW);
        4: p = '1;
        5: begin
          p.pair_tag = 16'hFFFF;
          p.a_center = pack3(32767, 32767, 32767, CW);
          p.b_center = pack3(-32768, -32768, -32768, CW);
        end
        6: p.a_half_size = pack3(-100, -100, -100, CW);
        7: begin
          p.b_axis_x = ident[1]; p.b_axis_y = ident[1]; p.b_axis_z = '0;
          p.b_center = pack3(150, 150, 150, CW);
        end
        8: begin
          p.b_axis_x = pack3(11585, 11585, 0, AxisW);
          p.b_axis_y = pack3(-11585, 11585, 0, AxisW);
          p.b_center = pack3(250, 250, 0, CW);
        end
        9: p.b_axis_x = pack3(-32768, 32767, -32768, AxisW);
        10: p.b_center = pack3(200, 0, 0, CW);
        11: p.b_center = pack3(201, 0, 0, CW);
        default: p = rand_pair();
      endcase
      send_pair(p);
    end
    drain();

    // random phases across bias settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (ph)
        0: write_bias(8'd0);
        3: write_bias(8'd255);
        5: write_bias(8'd1);
        default: write_bias(8'($urandom));
      endcase
      for (int n = 0; n < 210; n++) send_pair(rand_pair());
      drain();
    end

    $display("Sent %0d box pairs, checked %0d results (%0d overlaps), bias 0..255",
             n_sent, sb.n_checked, sb.n_hits);
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.n_err);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
